// ----- src/mlft_pkg.sv -----
// mlft_pkg: shared types and constants for the learning forward table
// widths of the header fields, learn status codes and the token that walks the cell chain
// no dependencies
package mlft_pkg;

  localparam int MAC_W               = 48;
  localparam int PORT_W              = 3;
  localparam int DEFAULT_TABLE_DEPTH = 16;

  // learn outcome codes, as reported on the result channel
  typedef enum logic [1:0] {
    LEARN_UPDATED = 2'd0,
    LEARN_ADDED   = 2'd1,
    LEARN_FULL    = 2'd2
  } learn_status_t;

  // one frame header in flight through the chain, plus its lookup progress
  typedef struct packed {
    logic              vld;       // a header occupies this stage
    logic [MAC_W-1:0]  src_mac;
    logic [MAC_W-1:0]  dst_mac;
    logic [PORT_W-1:0] port;      // ingress port
    logic              src_done;  // source already updated or learned
    learn_status_t     status;    // meaningful once src_done is set
    logic              dst_hit;   // destination found in an earlier cell
    logic [PORT_W-1:0] dst_port;  // port stored for the destination
  } hdr_token_t;

endpackage

// ----- src/mlft_cell.sv -----
// mlft_cell: one table entry plus one pipeline stage of the header chain
// depends on mlft_pkg for the token type and learn status codes
module mlft_cell import mlft_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  hdr_token_t tok_in,
  output hdr_token_t tok_out
);

  logic              valid_r, valid_nxt;
  logic [MAC_W-1:0]  addr_r, addr_nxt;
  logic [PORT_W-1:0] port_r, port_nxt;
  hdr_token_t        tok_r, tok_nxt;

  logic              src_match;
  logic              learn;
  logic              upd_valid;
  logic [MAC_W-1:0]  upd_addr;
  logic [PORT_W-1:0] upd_port;
  logic              dst_match;

  // source lookup: entries fill from index 0 and never free up, so the first
  // empty cell reached without a hit means the address is new
  assign src_match = tok_in.vld && valid_r && (addr_r == tok_in.src_mac);
  assign learn     = tok_in.vld && !valid_r && !tok_in.src_done;

  // entry as it looks after this header's update
  assign upd_valid = valid_r | learn;
  assign upd_addr  = learn ? tok_in.src_mac : addr_r;
  assign upd_port  = (src_match || learn) ? tok_in.port : port_r;

  // destination lookup against the updated entry, lowest index wins
  assign dst_match = tok_in.vld && !tok_in.dst_hit && upd_valid &&
                     (upd_addr == tok_in.dst_mac);

  // entry update
  always_comb begin
    valid_nxt = upd_valid;
    addr_nxt  = upd_addr;
    port_nxt  = upd_port;
  end

  // token handed to the next cell
  always_comb begin
    tok_nxt = tok_in;
    if (src_match) begin
      tok_nxt.src_done = 1'b1;
      tok_nxt.status   = LEARN_UPDATED;
    end else if (learn) begin
      tok_nxt.src_done = 1'b1;
      tok_nxt.status   = LEARN_ADDED;
    end
    if (dst_match) begin
      tok_nxt.dst_hit  = 1'b1;
      tok_nxt.dst_port = upd_port;
    end
  end

  // entry registers; address and port need no reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    addr_r <= addr_nxt;
    port_r <= port_nxt;
  end

  // stage register; only the occupancy bit is control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r.vld <= tok_nxt.vld;
    end
    tok_r.src_mac  <= tok_nxt.src_mac;
    tok_r.dst_mac  <= tok_nxt.dst_mac;
    tok_r.port     <= tok_nxt.port;
    tok_r.src_done <= tok_nxt.src_done;
    tok_r.status   <= tok_nxt.status;
    tok_r.dst_hit  <= tok_nxt.dst_hit;
    tok_r.dst_port <= tok_nxt.dst_port;
  end

  assign tok_out = tok_r;

endmodule

// ----- src/mac_learning_forward_table_unit.sv -----
// mac_learning_forward_table_unit: top level of the learning forward table
// chains TABLE_DEPTH mlft_cell instances and formats the decision; uses mlft_pkg
//
// The table is a chain of TABLE_DEPTH cells, one entry per cell. A header
// entered with start walks the chain one cell per cycle, learning its source
// address and looking up its destination on the way. The first cell registers
// the header at the transfer edge and a result register follows the last cell,
// so the decision is on the out_ ports with out_valid for one cycle once the
// header has passed all cell stages and the result register. A new header can
// be transferred in every cycle, so busy stays low; a header always sees the
// updates made by the headers before it.
// Results come out in input order, one per header, and cannot be held off.
// After reset the table is empty; there is no ageing, entries stay until reset.
module mac_learning_forward_table_unit import mlft_pkg::*; #(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [MAC_W-1:0]  in_src_mac,
  input  logic [MAC_W-1:0]  in_dst_mac,
  input  logic [PORT_W-1:0] in_port,
  output logic              out_valid,
  output logic              out_forward,
  output logic [PORT_W-1:0] out_port,
  output logic [1:0]        out_learn_status
);

  hdr_token_t chain [0:TABLE_DEPTH];
  hdr_token_t head_tok;
  hdr_token_t last_tok;

  logic              valid_r, valid_nxt;
  logic              forward_r, forward_nxt;
  logic [PORT_W-1:0] port_r, port_nxt;
  learn_status_t     status_r, status_nxt;

  // the chain takes a header every cycle
  assign busy = 1'b0;

  // header entering the first cell
  always_comb begin
    head_tok.vld      = start && !busy;
    head_tok.src_mac  = in_src_mac;
    head_tok.dst_mac  = in_dst_mac;
    head_tok.port     = in_port;
    head_tok.src_done = 1'b0;
    head_tok.status   = LEARN_FULL;
    head_tok.dst_hit  = 1'b0;
    head_tok.dst_port = '0;
  end

  assign chain[0] = head_tok;

  // row of table cells
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    mlft_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tok_in  (chain[g]),
      .tok_out (chain[g+1])
    );
  end

  assign last_tok = chain[TABLE_DEPTH];

  // forwarding decision at the end of the chain
  always_comb begin
    valid_nxt   = last_tok.vld;
    forward_nxt = last_tok.dst_hit && (last_tok.dst_port != last_tok.port);
    port_nxt    = forward_nxt ? last_tok.dst_port : '0;
    status_nxt  = last_tok.src_done ? last_tok.status : LEARN_FULL;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    forward_r <= forward_nxt;
    port_r    <= port_nxt;
    status_r  <= status_nxt;
  end

  assign out_valid        = valid_r;
  assign out_forward      = forward_r;
  assign out_port         = port_r;
  assign out_learn_status = status_r;

endmodule

// ----- verif/tb.sv -----
// tb: self-checking testbench for mac_learning_forward_table_unit
// directed header table followed by random headers, checked against a behavioral table model
// depends on mlft_pkg and the mac_learning_forward_table_unit rtl
`timescale 1ns / 1ps

module tb;
  import mlft_pkg::*;

  localparam int DEPTH       = DEFAULT_TABLE_DEPTH;
  localparam int LATENCY     = DEPTH + 1;
  localparam int RAND_ITEMS  = 1250;
  localparam int CYCLE_LIMIT = 100000;
  localparam int IDLE_PCT    = 28;
  localparam int CALM_FIRST  = 400;
  localparam int CALM_LAST   = 649;

  localparam logic [MAC_W-1:0] MAC_ZERO = '0;
  localparam logic [MAC_W-1:0] MAC_ONES = '1;
  localparam logic [MAC_W-1:0] MAC_A    = 48'h0200_0000_000A;
  localparam logic [MAC_W-1:0] MAC_B    = 48'h0200_0000_000B;
  localparam logic [MAC_W-1:0] MAC_C    = 48'h0200_0000_000C;

  // one forwarding decision as seen on the result ports
  typedef struct packed {
    logic              fwd;
    logic [PORT_W-1:0] egress;
    learn_status_t     status;
  } fwd_decision_t;

  // one row of the directed header table
  typedef struct packed {
    logic [MAC_W-1:0]  src;
    logic [MAC_W-1:0]  dst;
    logic [PORT_W-1:0] port;
    logic              typed;   // expectation typed in below, else predicted
    fwd_decision_t     want;
  } header_row_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [MAC_W-1:0]  in_src_mac;
  logic [MAC_W-1:0]  in_dst_mac;
  logic [PORT_W-1:0] in_port;
  logic              out_valid;
  logic              out_forward;
  logic [PORT_W-1:0] out_port;
  logic [1:0]        out_learn_status;

  // behavioral copy of the address table
  logic              tbl_valid [DEPTH];
  logic [MAC_W-1:0]  tbl_mac   [DEPTH];
  logic [PORT_W-1:0] tbl_port  [DEPTH];

  fwd_decision_t pending_decisions[$];
  header_row_t   header_rows[$];
  int            mismatch_count = 0;
  int            cycle_count = 0;

  mac_learning_forward_table_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_src_mac       (in_src_mac),
    .in_dst_mac       (in_dst_mac),
    .in_port          (in_port),
    .out_valid        (out_valid),
    .out_forward      (out_forward),
    .out_port         (out_port),
    .out_learn_status (out_learn_status)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // learn the source address, then look up the destination in the updated table
  task automatic learn_and_lookup(input logic [MAC_W-1:0] src, input logic [MAC_W-1:0] dst,
                                  input logic [PORT_W-1:0] port, output fwd_decision_t dec);
    int hit;
    int slot;
    hit  = -1;
    slot = -1;
    dec  = '{fwd: 1'b0, egress: '0, status: LEARN_FULL};
    for (int k = DEPTH - 1; k >= 0; k--) begin
      if (tbl_valid[k] && tbl_mac[k] == src) hit = k;
      if (!tbl_valid[k]) slot = k;
    end
    if (hit >= 0) begin
      tbl_port[hit] = port;
      dec.status = LEARN_UPDATED;
    end else if (slot >= 0) begin
      tbl_valid[slot] = 1'b1;
      tbl_mac[slot]   = src;
      tbl_port[slot]  = port;
      dec.status = LEARN_ADDED;
    end
    hit = -1;
    for (int k = DEPTH - 1; k >= 0; k--) begin
      if (tbl_valid[k] && tbl_mac[k] == dst) hit = k;
    end
    if (hit >= 0 && tbl_port[hit] != port) begin
      dec.fwd    = 1'b1;
      dec.egress = tbl_port[hit];
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // offer one header, optionally after an idle gap, and record its expected decision
  task automatic send_header(input logic [MAC_W-1:0] src, input logic [MAC_W-1:0] dst,
                             input logic [PORT_W-1:0] port, input logic typed,
                             input fwd_decision_t want, input logic may_idle);
    fwd_decision_t dec;
    if (may_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start      <= 1'b1;
    in_src_mac <= src;
    in_dst_mac <= dst;
    in_port    <= port;
    do @(posedge clk); while (busy);
    // transfer took place at this edge
    learn_and_lookup(src, dst, port, dec);
    pending_decisions.push_back(typed ? want : dec);
  endtask

  function automatic logic [MAC_W-1:0] random_mac();
    return MAC_W'({$urandom(), $urandom()});
  endfunction

  // pick an address the table already holds, or a random one if the picked entry is empty
  function automatic logic [MAC_W-1:0] known_mac();
    int k;
    k = $urandom_range(0, DEPTH - 1);
    return tbl_valid[k] ? tbl_mac[k] : random_mac();
  endfunction

  // result checker: one decision per strobe, oldest expectation first
  always @(posedge clk) begin
    fwd_decision_t exp_dec;
    if (rst_n && out_valid) begin
      if (pending_decisions.size() == 0) begin
        report_mismatch("unexpected result, forward", out_forward, 0);
      end else begin
        exp_dec = pending_decisions.pop_front();
        if (out_forward !== exp_dec.fwd)
          report_mismatch("forward", out_forward, exp_dec.fwd);
        if (out_port !== exp_dec.egress)
          report_mismatch("out_port", out_port, exp_dec.egress);
        if (out_learn_status !== exp_dec.status)
          report_mismatch("learn_status", out_learn_status, exp_dec.status);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("mac_learning_forward_table_unit: mismatch");
      $finish;
    end
  end

  initial begin
    logic [MAC_W-1:0]  src;
    logic [MAC_W-1:0]  dst;
    logic [PORT_W-1:0] port;
    int                pick;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_src_mac     = '0;
    in_dst_mac     = '0;
    in_port        = '0;
    for (int k = 0; k < DEPTH; k++) begin
      tbl_valid[k] = 1'b0;
      tbl_mac[k]   = '0;
      tbl_port[k]  = '0;
    end

    // directed headers: empty table, extremes, drops, then fill and overflow
    header_rows.push_back('{MAC_A, MAC_A, 3'd0, 1'b1, '{1'b0, 3'd0, LEARN_ADDED}});
    header_rows.push_back('{MAC_ZERO, MAC_ONES, 3'd7, 1'b1, '{1'b0, 3'd0, LEARN_ADDED}});
    header_rows.push_back('{MAC_ONES, MAC_ZERO, 3'd5, 1'b1, '{1'b1, 3'd7, LEARN_ADDED}});
    header_rows.push_back('{MAC_ZERO, MAC_ONES, 3'd7, 1'b1, '{1'b1, 3'd5, LEARN_UPDATED}});
    header_rows.push_back('{MAC_ZERO, MAC_ZERO, 3'd3, 1'b1, '{1'b0, 3'd0, LEARN_UPDATED}});
    header_rows.push_back('{MAC_B, MAC_ONES, 3'd5, 1'b1, '{1'b0, 3'd0, LEARN_ADDED}});
    for (int k = 0; k < DEPTH - 4; k++) begin
      header_rows.push_back('{48'h0A00_0000_0100 + MAC_W'(k), MAC_A, PORT_W'(k), 1'b0,
                              '{1'b0, 3'd0, LEARN_ADDED}});
    end
    // table is full from here on
    header_rows.push_back('{MAC_C, MAC_ZERO, 3'd1, 1'b1, '{1'b1, 3'd3, LEARN_FULL}});
    header_rows.push_back('{MAC_C, MAC_C, 3'd6, 1'b1, '{1'b0, 3'd0, LEARN_FULL}});
    header_rows.push_back('{MAC_A, MAC_B, 3'd2, 1'b1, '{1'b1, 3'd5, LEARN_UPDATED}});
    header_rows.push_back('{MAC_B, MAC_A, 3'd2, 1'b1, '{1'b0, 3'd0, LEARN_UPDATED}});

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (header_rows[i]) begin
      send_header(header_rows[i].src, header_rows[i].dst, header_rows[i].port,
                  header_rows[i].typed, header_rows[i].want, 1'b1);
    end

    // hold off until every directed decision has come back
    start <= 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk);

    // random headers: mostly known addresses, some unknown ones and self-addressed frames
    for (int n = 0; n < RAND_ITEMS; n++) begin
      src  = ($urandom_range(0, 99) < 75) ? known_mac() : random_mac();
      pick = $urandom_range(0, 99);
      if (pick < 10)      dst = src;
      else if (pick < 75) dst = known_mac();
      else                dst = random_mac();
      port = PORT_W'($urandom_range(0, 7));
      send_header(src, dst, port, 1'b0, '0, !(n >= CALM_FIRST && n <= CALM_LAST));
    end
    start <= 1'b0;

    // drain, then watch for stray results
    while (pending_decisions.size() != 0) @(posedge clk);
    repeat (2 * LATENCY + 4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("mac_learning_forward_table_unit: match");
    end else begin
      $display("mac_learning_forward_table_unit: mismatch");
    end
    $finish;
  end

endmodule
